// ----- rtl/qtsc_pkg.sv -----
package qtsc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W      = 16;
   localparam int MS_W       = 10;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_MANUAL_MODE  = 2'd0,
      REG_QUARTER_MS   = 2'd1,
      REG_DEBOUNCE_MS  = 2'd2,
      REG_START_WAIT   = 2'd3
   } reg_index_type;

   localparam logic             MANUAL_MODE_RST = 1'b0;
   localparam logic [MS_W-1:0]  QUARTER_MS_RST  = 10'd250;
   localparam logic [MS_W-1:0]  DEBOUNCE_MS_RST = 10'd50;
   localparam logic [CNT_W-1:0] START_WAIT_RST  = 16'd1000;

   localparam logic [CNT_W-1:0] CNT_MAX    = '1;
   localparam logic [1:0]       PHASE_RST  = 2'd3;
   localparam logic [1:0]       PHASE_SET  = 2'd1;
   localparam logic [1:0]       PHASE_IDLE = 2'd3;
   localparam logic [2:0]       STEP_FIRST = 3'd1;
   localparam logic [2:0]       STEP_BAD   = 3'd7;

   typedef struct packed {
      logic             manual_mode;
      logic [MS_W-1:0]  quarter_period_ms;
      logic [MS_W-1:0]  debounce_ms;
      logic [CNT_W-1:0] start_wait_ms;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic value;
   } mode_wr_type;

   typedef struct packed {
      logic [7:0] pattern;
      logic       pattern_updated;
      logic       waiting;
   } rsp_type;

   // one-hot step in bits 7..2 (step 1 at bit 7), enable in bit 1, set in bit 0
   function automatic logic [7:0] make_pattern(input logic [1:0] phase,
                                               input logic [2:0] step);
      logic [7:0] onehot;
      case (step)
         3'd1:    onehot = 8'h80;
         3'd2:    onehot = 8'h40;
         3'd3:    onehot = 8'h20;
         3'd4:    onehot = 8'h10;
         3'd5:    onehot = 8'h08;
         3'd6:    onehot = 8'h04;
         default: onehot = 8'h00;
      endcase
      return onehot | {6'b0, (phase != PHASE_IDLE), (phase == PHASE_SET)};
   endfunction

endpackage

// ----- rtl/quarter_tick_step_clock_generator_top.sv -----
// Quarter-tick step clock generator. Each req_ transfer is one millisecond tick
// carrying the sampled button level; each one yields exactly one rsp_ transfer
// with the held 8-bit pattern (one-hot step 1..6 in bits 7..2, enable in bit 1,
// set in bit 0), a flag that a quarter tick fired on this tick, and the waiting
// flag of automatic mode. The block takes one tick per clock cycle: the timer,
// debouncer and phase/step update sit in one short combinational pass that
// loads the result register, so a result appears the cycle after its transfer
// and a new tick is taken whenever the result register is empty or being
// drained. Registers (byte address): 0x0 manual_mode, 0x4 quarter_period_ms,
// 0x8 debounce_ms, 0xC start_wait_ms. Writing manual_mode also loads the
// debouncer levels with the written value. Write registers only while idle.
module quarter_tick_step_clock_generator_top
   import qtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_button_level,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_pattern,
   output logic                  rsp_pattern_updated,
   output logic                  rsp_waiting,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   mode_wr_type mode_wr;
   rsp_type     rsp_next;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;

   qtsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .mode_wr     (mode_wr)
   );

   // take a new tick whenever the result register frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   qtsc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .button_level (req_button_level),
      .cfg          (cfg),
      .mode_wr      (mode_wr),
      .rsp          (rsp_next)
   );

   // result register: load on accept, drop once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds until the next accepted tick
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pattern         = rsp_ff.pattern;
   assign rsp_pattern_updated = rsp_ff.pattern_updated;
   assign rsp_waiting         = rsp_ff.waiting;

endmodule

// ----- rtl/qtsc_csr.sv -----
module qtsc_csr
   import qtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output mode_wr_type           mode_wr
);

   cfg_type       cfg_ff, cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_MANUAL_MODE: cfg_in.manual_mode       = csr_pwdata[0];
            REG_QUARTER_MS:  cfg_in.quarter_period_ms = csr_pwdata[MS_W-1:0];
            REG_DEBOUNCE_MS: cfg_in.debounce_ms       = csr_pwdata[MS_W-1:0];
            REG_START_WAIT:  cfg_in.start_wait_ms     = csr_pwdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_mode       <= MANUAL_MODE_RST;
         cfg_ff.quarter_period_ms <= QUARTER_MS_RST;
         cfg_ff.debounce_ms       <= DEBOUNCE_MS_RST;
         cfg_ff.start_wait_ms     <= START_WAIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_MANUAL_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.manual_mode};
         REG_QUARTER_MS:  csr_prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.quarter_period_ms};
         REG_DEBOUNCE_MS: csr_prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.debounce_ms};
         REG_START_WAIT:  csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.start_wait_ms};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg           = cfg_ff;
   assign mode_wr.valid = wr_en && (idx == REG_MANUAL_MODE);
   assign mode_wr.value = csr_pwdata[0];

endmodule

// ----- rtl/qtsc_core.sv -----
module qtsc_core
   import qtsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        button_level,
   input  cfg_type     cfg,
   input  mode_wr_type mode_wr,
   output rsp_type     rsp
);

   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       step_ff, step_in;
   logic             running_ff, running_in;
   logic [CNT_W-1:0] elapsed_ff, elapsed_in;
   logic [CNT_W-1:0] steady_ff, steady_in;
   logic             stable_ff, stable_in;
   logic             prev_ff, prev_in;
   logic [7:0]       pattern_ff, pattern_in;

   logic             fire;
   logic [CNT_W-1:0] elapsed_inc;
   logic [2:0]       step_inc;

   assign elapsed_inc = (elapsed_ff == CNT_MAX) ? CNT_MAX : elapsed_ff + 1'b1;
   assign step_inc    = step_ff + 1'b1;

   always_comb begin
      fire       = 1'b0;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      steady_in  = steady_ff;
      stable_in  = stable_ff;
      prev_in    = prev_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      pattern_in = pattern_ff;

      if (accept) begin
         if (!cfg.manual_mode) begin
            elapsed_in = elapsed_inc;
            if (!running_ff) begin
               if (elapsed_inc >= cfg.start_wait_ms) begin
                  running_in = 1'b1;
               end
            end else if (elapsed_inc > {{(CNT_W-MS_W){1'b0}}, cfg.quarter_period_ms}) begin
               fire       = 1'b1;
               elapsed_in = '0;
            end
         end else begin
            if (button_level != prev_ff) begin
               steady_in = '0;
            end else begin
               steady_in = (steady_ff == CNT_MAX) ? CNT_MAX : steady_ff + 1'b1;
            end
            if ((steady_in > {{(CNT_W-MS_W){1'b0}}, cfg.debounce_ms}) &&
                (button_level != stable_ff)) begin
               stable_in = button_level;
               fire      = button_level;
            end
            prev_in = button_level;
         end

         // advance phase; step advances on every wrap to phase 0
         if (fire) begin
            phase_in = phase_ff + 1'b1;
            if (phase_in == 2'd0) begin
               step_in = (step_inc == STEP_BAD || step_inc == 3'd0) ? STEP_FIRST : step_inc;
            end
            pattern_in = make_pattern(phase_in, step_in);
         end
      end

      if (mode_wr.valid) begin
         stable_in = mode_wr.value;
         prev_in   = mode_wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_RST;
         step_ff    <= '0;
         running_ff <= 1'b0;
         elapsed_ff <= '0;
         steady_ff  <= '0;
         stable_ff  <= MANUAL_MODE_RST;
         prev_ff    <= MANUAL_MODE_RST;
         pattern_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         steady_ff  <= steady_in;
         stable_ff  <= stable_in;
         prev_ff    <= prev_in;
         pattern_ff <= pattern_in;
      end
   end

   assign rsp.pattern         = pattern_in;
   assign rsp.pattern_updated = fire;
   assign rsp.waiting         = !running_in;

`ifndef SYNTH
   a_timed_fire_running: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.manual_mode |-> running_ff)
      else $error("timed quarter tick before start");

   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_BAD)
      else $error("step count out of range");

   a_phase_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff))
      else $error("phase moved without quarter tick");

   a_run_only_auto: assert property (@(posedge clock) disable iff (reset)
      !running_ff && cfg.manual_mode |=> !running_ff)
      else $error("clock started in manual mode");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qtsc_pkg::*;

   // Ticks after the directed script, the long extreme phase included.
   localparam int unsigned RANDOM_TICKS = 1628;
   // Drop all idling once this close to the end of the random ticks.
   localparam int unsigned CALM_TAIL    = 350;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned SCRIPT_ROWS  = 34;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_button_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_pattern;
   logic                  rsp_pattern_updated;
   logic                  rsp_waiting;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   quarter_tick_step_clock_generator_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_button_level    (req_button_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pattern         (rsp_pattern),
      .rsp_pattern_updated (rsp_pattern_updated),
      .rsp_waiting         (rsp_waiting),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // ------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: the slowest legal run is well under a millisecond.
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Local copy of the clock generator: configuration and state
   // ------------------------------------------------------------------
   logic             mode_q;
   logic [MS_W-1:0]  period_q;
   logic [MS_W-1:0]  debounce_q;
   logic [CNT_W-1:0] start_wait_q;

   logic [1:0]       phase_q;
   logic [2:0]       step_q;
   logic             running_q;
   logic [CNT_W-1:0] elapsed_q;
   logic [CNT_W-1:0] steady_q;
   logic             stable_q;
   logic             prev_q;
   logic [7:0]       pattern_q;

   // Patterns still owed by the block, oldest first.
   rsp_type          expected_patterns[$];
   int unsigned      mismatches;
   int unsigned      ticks_sent;

   // Pinned expectation for the tick currently offered by the script.
   logic             pin_on;
   rsp_type          pin_want;

   // Idle odds: 0 means never, N means one in N per offered tick or ready update.
   int unsigned      gap_odds;
   int unsigned      stall_odds;

   function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Mirror a register write; the mode also reloads both debouncer levels.
   function automatic void apply_setting(input reg_index_type idx,
                                         input logic [31:0] value);
      case (idx)
         REG_MANUAL_MODE: begin
            mode_q   = value[0];
            stable_q = value[0];
            prev_q   = value[0];
         end
         REG_QUARTER_MS:  period_q     = value[MS_W-1:0];
         REG_DEBOUNCE_MS: debounce_q   = value[MS_W-1:0];
         REG_START_WAIT:  start_wait_q = value[CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] setting_value(input reg_index_type idx);
      case (idx)
         REG_MANUAL_MODE: return {31'd0, mode_q};
         REG_QUARTER_MS:  return {22'd0, period_q};
         REG_DEBOUNCE_MS: return {22'd0, debounce_q};
         default:         return {16'd0, start_wait_q};
      endcase
   endfunction

   // Advance the local copy by one millisecond tick and return the pattern it owes.
   function automatic rsp_type take_tick(input logic level);
      rsp_type    r;
      logic       fire;
      logic [7:0] onehot;
      fire = 1'b0;
      if (!mode_q) begin
         // timer: count the start wait first, then quarter periods
         elapsed_q = bump_sat(elapsed_q);
         if (!running_q) begin
            if (elapsed_q >= start_wait_q) running_q = 1'b1;
         end else if (elapsed_q > {6'd0, period_q}) begin
            fire      = 1'b1;
            elapsed_q = '0;
         end
      end else begin
         // debouncer: only an accepted rise fires
         if (level != prev_q) steady_q = '0;
         else                 steady_q = bump_sat(steady_q);
         if (steady_q > {6'd0, debounce_q} && level != stable_q) begin
            stable_q = level;
            fire     = level;
         end
         prev_q = level;
      end
      if (fire) begin
         phase_q = phase_q + 2'd1;
         if (phase_q == 2'd0) begin
            step_q = step_q + 3'd1;
            if (step_q == STEP_BAD || step_q == 3'd0) step_q = STEP_FIRST;
         end
         onehot = 8'h00;
         if (step_q >= 3'd1 && step_q <= 3'd6) onehot = 8'h80 >> (step_q - 3'd1);
         pattern_q = onehot | {6'd0, phase_q != PHASE_IDLE, phase_q == PHASE_SET};
      end
      r.pattern         = pattern_q;
      r.pattern_updated = fire;
      r.waiting         = !running_q;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: predict on every request transfer, check every result transfer.
   // Push before pop so the order holds for any latency.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = take_tick(req_button_level);
            if (pin_on) want = pin_want;
            expected_patterns.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_pattern, rsp_pattern_updated, rsp_waiting};
            if (expected_patterns.size() == 0) begin
               $error("result transfer with nothing expected: pattern %02h", seen.pattern);
               mismatches++;
            end else begin
               want = expected_patterns.pop_front();
               if (seen.pattern !== want.pattern) begin
                  $error("pattern: expected %02h, got %02h", want.pattern, seen.pattern);
                  mismatches++;
               end
               if (seen.pattern_updated !== want.pattern_updated) begin
                  $error("pattern_updated: expected %0b, got %0b",
                         want.pattern_updated, seen.pattern_updated);
                  mismatches++;
               end
               if (seen.waiting !== want.waiting) begin
                  $error("waiting: expected %0b, got %0b", want.waiting, seen.waiting);
                  mismatches++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: hold ready high, drop it at random in bursts.
   // ------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one tick at the falling edge, optionally after an idle burst, and
   // hold it until the transfer. Returns right after the accepting edge.
   task automatic send_tick(input logic level, input logic pinned = 1'b0,
                            input rsp_type want = '0);
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      pin_on   = pinned;
      pin_want = want;
      req_valid        <= 1'b1;
      req_button_level <= level;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic hold_level(input logic level, input int unsigned reps);
      repeat (reps) send_tick(level);
   endtask

   // Write one register once every owed result is in, then read it back.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] seen;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_patterns.size() != 0) @(posedge clock);
      @(negedge clock);
      // setup cycle
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      // access cycle: the register takes the value at the next rising edge
      csr_penable <= 1'b1;
      @(posedge clock);
      apply_setting(idx, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      seen = csr_prdata;
      if (seen !== setting_value(idx)) begin
         $error("%s readback: expected %0h, got %0h", idx.name(), setting_value(idx), seen);
         mismatches++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly clean presses with lengths around the debounce boundary (hold
   // for debounce+1 ticks does nothing, debounce+2 is accepted), with bounce.
   task automatic run_presses(input int unsigned budget);
      int unsigned first;
      first = ticks_sent;
      while (ticks_sent - first < budget) begin
         if ($urandom_range(0, 9) < 7) begin
            hold_level(1'b0, debounce_q + $urandom_range(0, 4));
            hold_level(1'b1, debounce_q + $urandom_range(0, 4));
         end else begin
            repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1));
         end
      end
   endtask

   // Pick an idle flavor per phase: none, heavy or light.
   function automatic int unsigned pick_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 8;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Directed script
   // ------------------------------------------------------------------
   typedef enum logic {ROW_TICK, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type    op;
      reg_index_type idx;
      logic [31:0]   value;
      logic          level;
      logic          pinned;
      rsp_type       want;
   } script_row_type;

   function automatic script_row_type set_row(input reg_index_type idx,
                                              input logic [31:0] value);
      script_row_type r;
      r = '{ROW_CSR, idx, value, 1'b0, 1'b0, '0};
      return r;
   endfunction

   function automatic script_row_type tick_row(input logic level);
      script_row_type r;
      r = '{ROW_TICK, REG_MANUAL_MODE, 32'd0, level, 1'b0, '0};
      return r;
   endfunction

   function automatic script_row_type pin_row(input logic level, input logic [7:0] pat,
                                              input logic upd, input logic wt);
      script_row_type r;
      r = '{ROW_TICK, REG_MANUAL_MODE, 32'd0, level, 1'b1, {pat, upd, wt}};
      return r;
   endfunction

   script_row_type script [SCRIPT_ROWS];

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned random_sent;
      int unsigned phase_no;
      int unsigned budget;
      int unsigned first;
      logic        manual;

      // drive every input to a known value and hold reset
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_button_level = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      pin_on           = 1'b0;
      pin_want         = '0;
      gap_odds         = 0;
      stall_odds       = 0;
      mismatches       = 0;
      ticks_sent       = 0;

      mode_q       = MANUAL_MODE_RST;
      period_q     = QUARTER_MS_RST;
      debounce_q   = DEBOUNCE_MS_RST;
      start_wait_q = START_WAIT_RST;
      phase_q      = PHASE_RST;
      step_q       = 3'd0;
      running_q    = 1'b0;
      elapsed_q    = '0;
      steady_q     = '0;
      stable_q     = MANUAL_MODE_RST;
      prev_q       = MANUAL_MODE_RST;
      pattern_q    = 8'h00;

      // The start wait only ever runs once (running never clears short of a
      // reset), so the script begins in manual mode while the clock still
      // waits, then switches to automatic mode to watch the start.
      script = '{
         set_row(REG_MANUAL_MODE, 1),
         set_row(REG_DEBOUNCE_MS, 0),
         // debounce 0: a level is taken on its second steady tick
         pin_row(1'b1, 8'h00, 1'b0, 1'b1),
         pin_row(1'b0, 8'h00, 1'b0, 1'b1),
         pin_row(1'b0, 8'h00, 1'b0, 1'b1),   // falling edge accepted, no tick
         pin_row(1'b1, 8'h00, 1'b0, 1'b1),
         pin_row(1'b1, 8'h82, 1'b1, 1'b1),   // rising edge: step 1, phase 0
         set_row(REG_DEBOUNCE_MS, 2),
         tick_row(1'b0), tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
         // short bounce restarts the count
         tick_row(1'b1), tick_row(1'b0), tick_row(1'b1),
         tick_row(1'b1), tick_row(1'b1),
         pin_row(1'b1, 8'h83, 1'b1, 1'b1),   // phase 1 carries set
         set_row(REG_DEBOUNCE_MS, 1023),
         tick_row(1'b1),
         // automatic mode: timer was frozen at 0 all along
         set_row(REG_MANUAL_MODE, 0),
         set_row(REG_QUARTER_MS, 3),
         set_row(REG_START_WAIT, 5),
         pin_row(1'b1, 8'h83, 1'b0, 1'b1),
         tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
         pin_row(1'b1, 8'h83, 1'b0, 1'b0),   // wait reached: clock runs
         pin_row(1'b0, 8'h82, 1'b1, 1'b0),   // wait exceeded the period: tick at once
         set_row(REG_QUARTER_MS, 1),
         tick_row(1'b1), tick_row(1'b0), tick_row(1'b1),
         pin_row(1'b0, 8'h42, 1'b1, 1'b0)    // fourth quarter: step 2
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the script with no idling so the pinned values stay simple
      foreach (script[i]) begin
         if (script[i].op == ROW_CSR) begin
            csr_write(script[i].idx, script[i].value);
         end else begin
            send_tick(script[i].level, script[i].pinned, script[i].want);
         end
      end

      // random phases: each picks a mode and settings, then runs ticks;
      // phase 2 holds the longest quarter period with one long run
      random_sent = 0;
      phase_no    = 0;
      while (random_sent < RANDOM_TICKS) begin
         if (random_sent + CALM_TAIL >= RANDOM_TICKS) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
         end
         first = ticks_sent;
         if (phase_no == 2) begin
            // longest quarter period: enough ticks for at least one fire
            csr_write(REG_MANUAL_MODE, 0);
            csr_write(REG_QUARTER_MS, 1000);
            csr_write(REG_START_WAIT, 65535);
            repeat (1005) send_tick($urandom_range(0, 1));
         end else begin
            manual = $urandom_range(0, 1);
            budget = $urandom_range(80, 200);
            csr_write(REG_MANUAL_MODE, manual);
            if (manual) begin
               csr_write(REG_DEBOUNCE_MS, ($urandom_range(0, 3) != 0) ?
                         $urandom_range(0, 6) : $urandom_range(7, 40));
            end else begin
               csr_write(REG_QUARTER_MS, ($urandom_range(0, 3) != 0) ?
                         $urandom_range(1, 8) : $urandom_range(9, 60));
            end
            // settings of the idle side must not disturb the active one
            if ($urandom_range(0, 3) == 0) begin
               if (manual) csr_write(REG_QUARTER_MS, $urandom_range(1, 1000));
               else        csr_write(REG_DEBOUNCE_MS, $urandom_range(0, 1023));
               csr_write(REG_START_WAIT, $urandom_range(0, 65535));
            end
            if (manual) begin
               run_presses(budget);
            end else begin
               repeat (budget) send_tick($urandom_range(0, 1));
            end
         end
         random_sent += ticks_sent - first;
         phase_no++;
      end

      // drop valid, let every owed result drain, then idle before the verdict
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_patterns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_patterns.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- quarter_tick_step_clock_generator_top.f -----
rtl/qtsc_pkg.sv
rtl/qtsc_csr.sv
rtl/qtsc_core.sv
rtl/quarter_tick_step_clock_generator_top.sv
tb/tb_top.sv
